// ----- hw/rtl/tpp_pkg.sv -----
// Shared types, constants and codes for the tricolor pixel packer.
// No dependencies; every other file in hw/rtl imports this package.
package tpp_pkg;

	// Limits and field widths
	localparam int MAX_ROW_PIXELS = 4096;
	localparam int CHAN_W         = 8;
	localparam int ROW_W          = 13;
	localparam int COL_W          = 12;
	localparam int PAD_W          = 2;
	localparam int IDX_W          = 2;

	// Row width ceiling, rounded down to a whole byte of pixels
	localparam logic [ROW_W-1:0] ROW_CAP  = ROW_W'(MAX_ROW_PIXELS - (MAX_ROW_PIXELS % 4));
	localparam logic [ROW_W-1:0] ROW_MIN  = ROW_W'(4);

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_THRESHOLD  = 2'd0;
	localparam logic [IDX_W-1:0] REG_ROW_PIXELS = 2'd1;
	localparam logic [IDX_W-1:0] REG_PAD_BYTES  = 2'd2;

	// Register reset values
	localparam logic [CHAN_W-1:0] THRESHOLD_RST  = 8'h7F;
	localparam logic [ROW_W-1:0]  ROW_PIXELS_RST = 13'd1600;
	localparam logic [PAD_W-1:0]  PAD_BYTES_RST  = 2'd2;

	// Pixel codes
	localparam logic [1:0] CODE_OTHER = 2'h0;
	localparam logic [1:0] CODE_WHITE = 2'h1;
	localparam logic [1:0] CODE_RED   = 2'h2;
	localparam logic [1:0] CODE_BLACK = 2'h3;

	// Bytes on the panel link
	localparam logic [7:0] MEMORY_WRITE_CMD = 8'h2C;
	localparam logic [7:0] PAD_BYTE         = 8'h00;

	// Job queue between front and back (depth must be a power of two)
	localparam int JQ_DEPTH = 4;
	localparam int JQ_AW    = $clog2(JQ_DEPTH);

	typedef struct packed {
		logic [CHAN_W-1:0] threshold;
		logic [ROW_W-1:0]  row_pixels;
		logic [PAD_W-1:0]  pad_bytes;
	} cfg_t;

	// One accepted pixel's worth of output work
	typedef struct packed {
		logic             is_cmd;
		logic             has_data;
		logic [7:0]       data;
		logic [PAD_W-1:0] pad_n;
	} job_t;

endpackage

// ----- hw/rtl/tpp_front.sv -----
// Front end: classifies each pixel, packs codes into bytes, tracks row position.
// Depends on tpp_pkg; emits one job per pixel that causes output.
module tpp_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic [tpp_pkg::CHAN_W-1:0]       blue,
	input  logic [tpp_pkg::CHAN_W-1:0]       green,
	input  logic [tpp_pkg::CHAN_W-1:0]       red,
	input  logic                             frame_start,
	input  tpp_pkg::cfg_t                    cfg,
	output logic                             job_valid,
	output tpp_pkg::job_t                    job
);
	import tpp_pkg::*;

	logic [5:0]       partial_q;
	logic [1:0]       slot_q;
	logic [COL_W-1:0] col_q;

	logic [5:0]       partial_eff;
	logic [1:0]       slot_eff;
	logic [COL_W-1:0] col_eff;
	logic [1:0]       code;
	logic [ROW_W-1:0] width_raw;
	logic [ROW_W-1:0] width;
	logic [ROW_W-1:0] col_inc;
	logic             complete;
	logic             row_end;
	logic [5:0]       partial_nxt;

	// frame start clears the packing state before this pixel lands
	assign partial_eff = frame_start ? 6'd0 : partial_q;
	assign slot_eff    = frame_start ? 2'd0 : slot_q;
	assign col_eff     = frame_start ? '0 : col_q;

	always_comb begin
		case ({blue > cfg.threshold, green > cfg.threshold, red > cfg.threshold})
			3'b111:  code = CODE_WHITE;
			3'b001:  code = CODE_RED;
			3'b000:  code = CODE_BLACK;
			default: code = CODE_OTHER;
		endcase
	end

	always_comb begin
		width_raw = {cfg.row_pixels[ROW_W-1:2], 2'b00};
		if (width_raw == '0) begin
			width = ROW_MIN;
		end else if (width_raw > ROW_CAP) begin
			width = ROW_CAP;
		end else begin
			width = width_raw;
		end
	end

	assign complete = (slot_eff == 2'd3);
	assign col_inc  = {1'b0, col_eff} + ROW_W'(1);
	assign row_end  = (col_inc >= width);

	always_comb begin
		partial_nxt = partial_eff;
		case (slot_eff)
			2'd0:    partial_nxt[1:0] = code;
			2'd1:    partial_nxt[3:2] = code;
			2'd2:    partial_nxt[5:4] = code;
			default: partial_nxt      = 6'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			slot_q    <= '0;
			col_q     <= '0;
		end else if (accept) begin
			partial_q <= partial_nxt;
			slot_q    <= slot_eff + 2'd1;
			if (complete && row_end) begin
				col_q <= '0;
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

	assign job_valid    = accept && (frame_start || complete);
	assign job.is_cmd   = frame_start;
	assign job.has_data = complete;
	assign job.data     = {code, partial_eff};
	assign job.pad_n    = (complete && row_end) ? cfg.pad_bytes : '0;

endmodule

// ----- hw/rtl/tpp_jobq.sv -----
// Short job queue parting the front and back ends.
// Depends on tpp_pkg for the job type and depth.
module tpp_jobq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  tpp_pkg::job_t wr_job,
	input  logic          rd_en,
	output logic          full,
	output logic          head_valid,
	output tpp_pkg::job_t head_job
);
	import tpp_pkg::*;

	job_t             mem_q [JQ_DEPTH];
	logic [JQ_AW-1:0] wr_ptr_q;
	logic [JQ_AW-1:0] rd_ptr_q;
	logic [JQ_AW:0]   count_q;

	assign full       = (count_q == (JQ_AW+1)'(JQ_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/tpp_back.sv -----
// Back end: expands each job into command, data and pad bytes, one per cycle
// while bytes are popped, into a registered output stage. Depends on tpp_pkg.
module tpp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  tpp_pkg::job_t head_job,
	output logic          job_done,
	input  logic          pop,
	output logic          empty,
	output logic [7:0]    out_byte,
	output logic          is_command,
	output logic          last
);
	import tpp_pkg::*;

	logic [2:0] step_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       cmd_q;
	logic       last_q;

	logic [2:0] total;
	logic [2:0] data_step;
	logic [7:0] nxt_byte;
	logic       nxt_cmd;
	logic       nxt_last;
	logic       load;

	assign total     = {2'b00, head_job.is_cmd} + {2'b00, head_job.has_data}
	                 + {1'b0, head_job.pad_n};
	assign data_step = {2'b00, head_job.is_cmd};

	always_comb begin
		if (head_job.is_cmd && step_q == 3'd0) begin
			nxt_byte = MEMORY_WRITE_CMD;
			nxt_cmd  = 1'b1;
		end else if (head_job.has_data && step_q == data_step) begin
			nxt_byte = head_job.data;
			nxt_cmd  = 1'b0;
		end else begin
			nxt_byte = PAD_BYTE;
			nxt_cmd  = 1'b0;
		end
	end

	assign nxt_last = (step_q == total - 3'd1);
	assign load     = head_valid && (!out_valid_q || pop);
	assign job_done = load && nxt_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q <= nxt_last ? 3'd0 : step_q + 3'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= nxt_byte;
			cmd_q  <= nxt_cmd;
			last_q <= nxt_last;
		end
	end

	assign empty      = !out_valid_q;
	assign out_byte   = byte_q;
	assign is_command = cmd_q;
	assign last       = last_q;

endmodule

// ----- hw/rtl/tricolor_pixel_packer_core.sv -----
// Top level of the tricolor pixel packer: config registers, front, job queue, back.
// Depends on tpp_pkg, tpp_front, tpp_jobq and tpp_back.
//
// Channel   Direction  Handshake            Payload
// pixel     in         push / full          blue, green, red, frame_start
// bytes     out        empty / pop          out_byte, is_command, last
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One pixel accepted per clock while the four-entry job queue has room.
// Each byte request leaves the back end at one per clock, while popped, from a
// registered output stage; a pixel that ends a row adds up to three pad bytes,
// so sustained pixel rate holds at one per clock unless pads outrun the queue.
// full rises only when the job queue holds four pending jobs.
// Reset is asynchronous, active low; it restores register defaults and
// clears packing state, queue and output stage. Config is always ready.
module tricolor_pixel_packer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// pixel input
	input  logic                          push,
	output logic                          full,
	input  logic [tpp_pkg::CHAN_W-1:0]    blue,
	input  logic [tpp_pkg::CHAN_W-1:0]    green,
	input  logic [tpp_pkg::CHAN_W-1:0]    red,
	input  logic                          frame_start,
	// byte output
	output logic                          empty,
	input  logic                          pop,
	output logic [7:0]                    out_byte,
	output logic                          is_command,
	output logic                          last,
	// config write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tpp_pkg::IDX_W-1:0]     cfg_index,
	input  logic [tpp_pkg::ROW_W-1:0]     cfg_data
);
	import tpp_pkg::*;

	cfg_t cfg_q;
	logic accept;
	logic job_valid;
	job_t job;
	logic head_valid;
	job_t head_job;
	logic job_done;

	// Config registers; writes beyond the register list are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold  <= THRESHOLD_RST;
			cfg_q.row_pixels <= ROW_PIXELS_RST;
			cfg_q.pad_bytes  <= PAD_BYTES_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_THRESHOLD:  cfg_q.threshold  <= cfg_data[CHAN_W-1:0];
				REG_ROW_PIXELS: cfg_q.row_pixels <= cfg_data;
				REG_PAD_BYTES:  cfg_q.pad_bytes  <= cfg_data[PAD_W-1:0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	// A pixel request is taken whenever the queue can hold its job
	assign accept = push && !full;

	tpp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.blue        (blue),
		.green       (green),
		.red         (red),
		.frame_start (frame_start),
		.cfg         (cfg_q),
		.job_valid   (job_valid),
		.job         (job)
	);

	tpp_jobq u_jobq (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (job_valid),
		.wr_job     (job),
		.rd_en      (job_done),
		.full       (full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	tpp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.job_done   (job_done),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.is_command (is_command),
		.last       (last)
	);

	// A command request always carries the memory-write opcode
	a_cmd_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && is_command) |-> (out_byte == MEMORY_WRITE_CMD))
		else $error("command byte is not the memory-write opcode");

	// Taking a non-final byte of a job leaves the next one ready in the following cycle
	a_job_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last) |=> !empty)
		else $error("gap inside the bytes of one pixel");

	// The queue only reports full while it has jobs waiting for the back end
	a_full_head: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> head_valid)
		else $error("queue full with no head job");

endmodule
